[rtl/fcl_pkg.sv]
package fcl_pkg;

  // Store and walk sizing
  localparam int TABLE_BYTES = 8192;
  localparam int LINK_CAP    = 4096;

  localparam int ADDR_W  = $clog2(TABLE_BYTES);
  localparam int LINK_W  = $clog2(LINK_CAP + 1);
  localparam int CLUS_W  = 12;
  localparam int LEN_W   = 13;
  localparam int IDX_W   = 13;
  // Byte offset of a cluster's pair of bytes: 3*(c/2)+c[0]+1 stays below 2^13
  localparam int RAW_W   = 13;
  localparam int LEN_MAX = 8191;

  // Entry decode constants
  localparam logic [7:0]        NIB_HI    = 8'hf0;
  localparam logic [7:0]        NIB_LO    = 8'h0f;
  localparam logic [CLUS_W-1:0] ENT_MIN   = 12'h002;
  localparam logic [CLUS_W-1:0] ENT_END   = 12'hff0;

  // Request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [IDX_W-1:0]  byte_index;
    logic [7:0]        byte_value;
    logic [CLUS_W-1:0] first_clus;
  } in_req_t;

  typedef struct packed {
    logic [LEN_W-1:0] chain_length;
    logic             cap_hit;
  } out_res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } tbl_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr_lo;
    logic [ADDR_W-1:0] addr_hi;
  } tbl_rd_t;

endpackage

[rtl/fat12_chain_length.sv]
// FAT12 cluster-chain length unit. Load requests (req_type 0) write one byte
// of the local allocation table and do not raise busy; they produce no
// result. Query requests (req_type 1) walk the chain from first_clus and
// return one result: one plus the number of entries read, and cap_hit when
// the walk stopped at the link cap with the chain still open. A request is
// taken at a rising edge with start high and busy low. A query holds busy
// until its walk has ended; the result shows on out_res for exactly one
// cycle with out_valid high, in the cycle that busy drops, so a new request
// may be taken while the result is presented. Each link takes a TEST step,
// which issues the two byte addresses to the table store with its registered
// read ports, and an EVAL step, which decodes the 12-bit entry from the read
// data. The receiver cannot stall the result and must capture it in that one
// cycle. Table bytes are undefined until loaded; no clearing pass runs after
// reset, and a query must only touch loaded bytes.
module fat12_chain_length import fcl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_valid,
  output out_res_t out_res
);

  tbl_wr_t    wr;
  tbl_rd_t    rd;
  logic [7:0] rd_lo;
  logic [7:0] rd_hi;

  // Walk control: takes requests, steers loads and chain reads, builds results
  fcl_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .wr        (wr),
    .rd        (rd),
    .rd_lo     (rd_lo),
    .rd_hi     (rd_hi)
  );

  // Table store: one write port, two registered read ports for the byte pair
  fcl_table u_table (
    .clk   (clk),
    .wr    (wr),
    .rd    (rd),
    .rd_lo (rd_lo),
    .rd_hi (rd_hi)
  );

endmodule

[rtl/fcl_table.sv]
module fcl_table import fcl_pkg::*; (
  input  logic     clk,
  input  tbl_wr_t  wr,
  input  tbl_rd_t  rd,
  output logic [7:0] rd_lo,
  output logic [7:0] rd_hi
);

  logic [7:0] mem [TABLE_BYTES];
  logic [7:0] rd_lo_r;
  logic [7:0] rd_hi_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_lo_r <= mem[rd.addr_lo];
      rd_hi_r <= mem[rd.addr_hi];
    end
  end

  assign rd_lo = rd_lo_r;
  assign rd_hi = rd_hi_r;

endmodule

[rtl/fcl_walk.sv]
module fcl_walk import fcl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_req_t    in_req,
  output logic       out_valid,
  output out_res_t   out_res,
  output tbl_wr_t    wr,
  output tbl_rd_t    rd,
  input  logic [7:0] rd_lo,
  input  logic [7:0] rd_hi
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_TEST = 3'b010,
    ST_EVAL = 3'b100
  } state_t;

  localparam int CAP_LEN = (LINK_CAP + 1 > LEN_MAX) ? LEN_MAX : LINK_CAP + 1;

  state_t            state_r, state_nxt;
  logic [CLUS_W-1:0] clus_r, clus_nxt;
  logic [LINK_W-1:0] links_r, links_nxt;
  logic              oor_lo_r, oor_lo_nxt;
  logic              oor_hi_r, oor_hi_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_res_t          out_res_r, out_res_nxt;

  logic              accept;
  logic              done;
  logic [RAW_W-1:0]  base;
  logic [RAW_W-1:0]  raw_lo;
  logic [RAW_W-1:0]  raw_hi;
  logic [7:0]        byte_lo;
  logic [7:0]        byte_hi;
  logic [CLUS_W-1:0] entry;
  logic [CLUS_W-1:0] next_clus;
  logic [LINK_W:0]   len_wide;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // Load path: one byte per accepted load, dropped when beyond the store
  always_comb begin
    wr.we   = accept && (in_req.req_type == REQ_LOAD)
              && (32'(in_req.byte_index) < TABLE_BYTES);
    wr.addr = ADDR_W'(in_req.byte_index);
    wr.data = in_req.byte_value;
  end

  // Pair of bytes holding the entry: even takes b0,b1; odd takes b1,b2
  always_comb begin
    base   = RAW_W'({clus_r[CLUS_W-1:1], 1'b0}) + RAW_W'(clus_r[CLUS_W-1:1]);
    raw_lo = base + RAW_W'(clus_r[0]);
    raw_hi = raw_lo + RAW_W'(1);
  end

  assign done = (clus_r == '0) || (links_r == LINK_W'(LINK_CAP));

  always_comb begin
    rd.en      = (state_r == ST_TEST) && !done;
    rd.addr_lo = ADDR_W'(raw_lo);
    rd.addr_hi = ADDR_W'(raw_hi);
  end

  // Decode the entry from the registered read data
  always_comb begin
    byte_lo = oor_lo_r ? 8'h00 : rd_lo;
    byte_hi = oor_hi_r ? 8'h00 : rd_hi;
    if (clus_r[0]) begin
      entry = {byte_hi, 4'((byte_lo & NIB_HI) >> 4)};
    end else begin
      entry = {4'(byte_hi & NIB_LO), byte_lo};
    end
    next_clus = ((entry < ENT_MIN) || (entry >= ENT_END)) ? '0 : entry;
  end

  always_comb begin
    len_wide = {1'b0, links_r} + (LINK_W + 1)'(1);
  end

  always_comb begin
    state_nxt     = state_r;
    clus_nxt      = clus_r;
    links_nxt     = links_r;
    oor_lo_nxt    = oor_lo_r;
    oor_hi_nxt    = oor_hi_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_req.req_type == REQ_QUERY)) begin
          clus_nxt  = in_req.first_clus;
          links_nxt = '0;
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if (done) begin
          out_valid_nxt            = 1'b1;
          out_res_nxt.cap_hit      = (clus_r != '0);
          out_res_nxt.chain_length = (32'(len_wide) > LEN_MAX) ? LEN_W'(LEN_MAX)
                                                               : LEN_W'(len_wide);
          state_nxt                = ST_IDLE;
        end else begin
          oor_lo_nxt = !(32'(raw_lo) < TABLE_BYTES);
          oor_hi_nxt = !(32'(raw_hi) < TABLE_BYTES);
          state_nxt  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        clus_nxt  = next_clus;
        links_nxt = links_r + LINK_W'(1);
        state_nxt = ST_TEST;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    clus_r    <= clus_nxt;
    links_r   <= links_nxt;
    oor_lo_r  <= oor_lo_nxt;
    oor_hi_r  <= oor_hi_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // A result only follows a finished test step
  a_result_after_test: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_TEST))
    else $error("result without finished walk");

  // The link count never passes the cap
  a_links_capped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (32'(links_r) <= LINK_CAP))
    else $error("link count beyond cap");

  // A capped walk reports the capped length
  a_cap_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.cap_hit) |-> (32'(out_res_r.chain_length) == CAP_LEN))
    else $error("cap flag with wrong length");

  // An accepted query holds the block busy
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req.req_type == REQ_QUERY)) |=> busy)
    else $error("query accepted without going busy");

endmodule
